### rtl/assert_macros.svh
// Assertion macros used by the checker module of the LED bar block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/fplb_pkg.sv
// Types and constants shared by the flight phase LED bar pattern block.
package fplb_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned DIV_NUM_W   = 24;
   localparam int unsigned DIV_DEN_W   = 16;
   localparam int unsigned DIFF_W      = 18;
   localparam int unsigned PROD_W      = 26;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [3:0]             phase_type;
   typedef logic [2:0]             color_type;

   localparam csr_index_type CSR_NUM_LEDS      = 4'd0;
   localparam csr_index_type CSR_BREAKOFF_ALT  = 4'd1;
   localparam csr_index_type CSR_EXIT_ALT      = 4'd2;
   localparam csr_index_type CSR_DEPLOY_ALT    = 4'd3;
   localparam csr_index_type CSR_FLASH_ON      = 4'd4;
   localparam csr_index_type CSR_FLASH_OFF     = 4'd5;
   localparam csr_index_type CSR_STANDBY_LEVEL = 4'd6;
   localparam csr_index_type CSR_FLIGHT_LEVEL  = 4'd7;

   localparam phase_type PH_STANDBY      = 4'd0;
   localparam phase_type PH_ASCENT       = 4'd1;
   localparam phase_type PH_GEAR_CHECK   = 4'd2;
   localparam phase_type PH_AWAIT_JUMP   = 4'd3;
   localparam phase_type PH_FREEFALL     = 4'd4;
   localparam phase_type PH_NEAR_BREAKOFF = 4'd5;
   localparam phase_type PH_BREAKOFF     = 4'd6;
   localparam phase_type PH_TRACK        = 4'd7;
   localparam phase_type PH_DEPLOY       = 4'd8;
   localparam phase_type PH_CANOPY       = 4'd9;

   localparam color_type COLOR_PURPLE = 3'd0;
   localparam color_type COLOR_GREEN  = 3'd1;
   localparam color_type COLOR_YELLOW = 3'd2;
   localparam color_type COLOR_SKY    = 3'd3;
   localparam color_type COLOR_RED    = 3'd4;

   localparam logic [31:0] BLINK_WINDOW_MS    = 32'd3000;
   localparam logic [15:0] BREAKOFF_MARGIN_FT = 16'd1500;
   localparam logic [15:0] DEPLOY_MARGIN_FT   = 16'd500;
   localparam logic [15:0] GEAR_STEP_DIV      = 16'd7;
   localparam logic [15:0] CANOPY_STEP_DIV    = 16'd10;

   typedef struct packed {
      logic [5:0]  num_leds;
      logic [15:0] breakoff_altitude;
      logic [15:0] exit_altitude;
      logic [15:0] deploy_altitude;
      logic [15:0] flash_on_ms;
      logic [15:0] flash_off_ms;
      logic [7:0]  standby_level;
      logic [7:0]  flight_level;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

### rtl/fplb_if.sv
// Channel interfaces for the update, result and register write transfers.
interface fplb_req_if;
   logic                 valid;
   logic                 ready;
   fplb_pkg::phase_type  phase;
   logic [15:0]          step;
   logic [15:0]          altitude;
   logic [31:0]          now_ms;

   modport source (output valid, phase, step, altitude, now_ms, input ready);
   modport sink (input valid, phase, step, altitude, now_ms, output ready);
endinterface

interface fplb_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [5:0]           lit_count;
   fplb_pkg::color_type  color;
   logic [7:0]           level;

   modport source (output valid, lit_count, color, level, input ready);
   modport sink (input valid, lit_count, color, level, output ready);
endinterface

interface fplb_csr_if;
   logic                                valid;
   logic                                ready;
   fplb_pkg::csr_index_type             index;
   logic [fplb_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/fplb_csr_regs.sv
// Configuration register file written through the register write channel.
module fplb_csr_regs (
   input  logic              clock,
   input  logic              reset,
   fplb_csr_if.sink          csr_bus,
   output fplb_pkg::cfg_type cfg
);

   fplb_pkg::cfg_type cfg_ff;
   fplb_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            fplb_pkg::CSR_NUM_LEDS:      cfg_in.num_leds          = csr_bus.data[5:0];
            fplb_pkg::CSR_BREAKOFF_ALT:  cfg_in.breakoff_altitude = csr_bus.data;
            fplb_pkg::CSR_EXIT_ALT:      cfg_in.exit_altitude     = csr_bus.data;
            fplb_pkg::CSR_DEPLOY_ALT:    cfg_in.deploy_altitude   = csr_bus.data;
            fplb_pkg::CSR_FLASH_ON:      cfg_in.flash_on_ms       = csr_bus.data;
            fplb_pkg::CSR_FLASH_OFF:     cfg_in.flash_off_ms      = csr_bus.data;
            fplb_pkg::CSR_STANDBY_LEVEL: cfg_in.standby_level     = csr_bus.data[7:0];
            fplb_pkg::CSR_FLIGHT_LEVEL:  cfg_in.flight_level      = csr_bus.data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_leds          <= 6'd10;
         cfg_ff.breakoff_altitude <= 16'd4500;
         cfg_ff.exit_altitude     <= 16'd13500;
         cfg_ff.deploy_altitude   <= 16'd3500;
         cfg_ff.flash_on_ms       <= 16'd100;
         cfg_ff.flash_off_ms      <= 16'd2000;
         cfg_ff.standby_level     <= 8'd10;
         cfg_ff.flight_level      <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/fplb_serial_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
module fplb_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fplb_pkg::div_req_type div_req,
   output fplb_pkg::div_rsp_type div_rsp
);

   localparam int unsigned NUM_W = fplb_pkg::DIV_NUM_W;
   localparam int unsigned DEN_W = fplb_pkg::DIV_DEN_W;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_sub;
   logic             take;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign take      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], take};
         rem_in = take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule

### rtl/flight_phase_led_bar_pattern.sv
// Top level of the flight phase LED bar pattern block.
// An update passes through the prepare, multiply, divider start, divide and finish
// states; the next update is taken only once the result has been registered.
// The division uses the 24-bit serial divider, one quotient bit per cycle.
// A synchronous reset restores the register defaults and clears the display state.
module flight_phase_led_bar_pattern #(
   parameter int MAX_LEDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   fplb_req_if.sink    req_bus,
   fplb_rsp_if.source  rsp_bus,
   fplb_csr_if.sink    csr_bus
);

   localparam int unsigned DIFF_W = fplb_pkg::DIFF_W;
   localparam int unsigned PROD_W = fplb_pkg::PROD_W;
   localparam int unsigned NUM_W  = fplb_pkg::DIV_NUM_W;
   localparam logic [7:0]  MAX_LEDS_LIM = 8'(MAX_LEDS);

   typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_START, S_DIV, S_FIN} state_type;

   fplb_pkg::cfg_type     cfg;
   fplb_pkg::div_req_type div_req;
   fplb_pkg::div_rsp_type div_rsp;

   state_type                  state_ff, state_in;
   fplb_pkg::phase_type        phase_ff, phase_in;
   logic [15:0]                step_ff, step_in;
   logic [15:0]                alt_ff, alt_in;
   logic [31:0]                now_ff, now_in;
   logic [5:0]                 n_ff, n_in;
   logic [16:0]                len_ff, len_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic [6:0]                 factor_ff, factor_in;
   logic                       span_pos_ff, span_pos_in;
   logic [15:0]                den_ff, den_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [31:0]                cyc_end_ff, cyc_end_in;
   logic [31:0]                off_end_ff, off_end_in;
   logic [31:0]                cs_ff, cs_in;
   logic [5:0]                 shown_count_ff, shown_count_in;
   fplb_pkg::color_type        shown_color_ff, shown_color_in;
   logic [7:0]                 shown_level_ff, shown_level_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [5:0]                 out_count_ff, out_count_in;
   fplb_pkg::color_type        out_color_ff, out_color_in;
   logic [7:0]                 out_level_ff, out_level_in;

   logic [5:0]          n_now;
   logic [DIFF_W-1:0]   span;
   logic [NUM_W-1:0]    quot;
   logic [NUM_W:0]      quot_inc;
   logic [5:0]          lit_fill;
   logic [5:0]          lit_fill_inc;
   logic                prod_neg;
   logic                new_cycle;
   logic                bar_on;

   fplb_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   fplb_serial_div u_serial_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign n_now = ({2'b00, cfg.num_leds} > MAX_LEDS_LIM) ? MAX_LEDS_LIM[5:0] : cfg.num_leds;
   assign span  = {2'b00, cfg.exit_altitude} - {2'b00, cfg.breakoff_altitude}
                  - {2'b00, fplb_pkg::BREAKOFF_MARGIN_FT};

   assign prod_neg     = prod_ff[PROD_W-1];
   assign quot         = div_rsp.quot;
   assign quot_inc     = {1'b0, quot} + 1'b1;
   assign lit_fill     = (quot > NUM_W'(n_ff)) ? n_ff : quot[5:0];
   assign lit_fill_inc = (quot_inc > (NUM_W + 1)'(n_ff)) ? n_ff : quot_inc[5:0];
   assign new_cycle    = now_ff > cyc_end_ff;
   assign bar_on       = off_end_ff < now_ff;

   assign div_req.start = (state_ff == S_START);
   assign div_req.den   = den_ff;
   assign div_req.num   = ((phase_ff == fplb_pkg::PH_GEAR_CHECK) ||
                           (phase_ff == fplb_pkg::PH_CANOPY)) ? NUM_W'(step_ff) :
                          (prod_neg ? '0 : prod_ff[NUM_W-1:0]);

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.lit_count = out_count_ff;
   assign rsp_bus.color     = out_color_ff;
   assign rsp_bus.level     = out_level_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      step_in        = step_ff;
      alt_in         = alt_ff;
      now_in         = now_ff;
      n_in           = n_ff;
      len_in         = len_ff;
      diff_in        = diff_ff;
      factor_in      = factor_ff;
      span_pos_in    = span_pos_ff;
      den_in         = den_ff;
      prod_in        = prod_ff;
      cyc_end_in     = cyc_end_ff;
      off_end_in     = off_end_ff;
      cs_in          = cs_ff;
      shown_count_in = shown_count_ff;
      shown_color_in = shown_color_ff;
      shown_level_in = shown_level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      out_count_in   = out_count_ff;
      out_color_in   = out_color_ff;
      out_level_in   = out_level_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               phase_in = req_bus.phase;
               step_in  = req_bus.step;
               alt_in   = req_bus.altitude;
               now_in   = req_bus.now_ms;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            n_in        = n_now;
            len_in      = {1'b0, cfg.flash_on_ms} + {1'b0, cfg.flash_off_ms};
            span_pos_in = !span[DIFF_W-1] && (span != '0);
            factor_in   = (phase_ff == fplb_pkg::PH_FREEFALL) ? {1'b0, n_now} :
                          ({1'b0, n_now} + 7'd1);
            unique case (phase_ff)
               fplb_pkg::PH_FREEFALL: begin
                  diff_in = {2'b00, cfg.exit_altitude} - {2'b00, alt_ff};
                  den_in  = span[15:0];
               end
               fplb_pkg::PH_NEAR_BREAKOFF: begin
                  diff_in = {2'b00, cfg.breakoff_altitude}
                            + {2'b00, fplb_pkg::BREAKOFF_MARGIN_FT} - {2'b00, alt_ff};
                  den_in  = fplb_pkg::BREAKOFF_MARGIN_FT;
               end
               fplb_pkg::PH_TRACK: begin
                  diff_in = {2'b00, cfg.deploy_altitude}
                            + {2'b00, fplb_pkg::DEPLOY_MARGIN_FT} - {2'b00, alt_ff};
                  den_in  = fplb_pkg::DEPLOY_MARGIN_FT;
               end
               fplb_pkg::PH_CANOPY: begin
                  diff_in = '0;
                  den_in  = fplb_pkg::CANOPY_STEP_DIV;
               end
               default: begin
                  diff_in = '0;
                  den_in  = fplb_pkg::GEAR_STEP_DIV;
               end
            endcase
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in    = PROD_W'(diff_ff * $signed({1'b0, factor_ff}));
            cyc_end_in = cs_ff + {15'b0, len_ff};
            off_end_in = cs_ff + {16'b0, cfg.flash_off_ms};
            state_in   = S_START;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               if (phase_ff <= fplb_pkg::PH_CANOPY) begin
                  shown_level_in = (phase_ff == fplb_pkg::PH_STANDBY) ? cfg.standby_level :
                                   cfg.flight_level;
               end
               unique case (phase_ff)
                  fplb_pkg::PH_STANDBY: begin
                     if ((cs_ff == '0) && (now_ff < fplb_pkg::BLINK_WINDOW_MS)) begin
                        shown_count_in = step_ff[0] ? 6'd0 : n_ff;
                        shown_color_in = fplb_pkg::COLOR_PURPLE;
                     end else if (new_cycle) begin
                        cs_in = now_ff;
                     end else begin
                        shown_count_in = bar_on ? n_ff : 6'd0;
                        shown_color_in = fplb_pkg::COLOR_GREEN;
                     end
                  end
                  fplb_pkg::PH_ASCENT: begin
                     if (new_cycle) begin
                        cs_in = now_ff;
                     end else begin
                        shown_count_in = bar_on ? n_ff : 6'd0;
                        shown_color_in = fplb_pkg::COLOR_YELLOW;
                     end
                  end
                  fplb_pkg::PH_GEAR_CHECK: begin
                     shown_count_in = quot[0] ? 6'd0 : n_ff;
                     shown_color_in = fplb_pkg::COLOR_GREEN;
                  end
                  fplb_pkg::PH_AWAIT_JUMP: begin
                     shown_count_in = n_ff;
                     shown_color_in = fplb_pkg::COLOR_SKY;
                  end
                  fplb_pkg::PH_FREEFALL: begin
                     shown_count_in = !span_pos_ff ? n_ff : (prod_neg ? 6'd0 : lit_fill_inc);
                     shown_color_in = fplb_pkg::COLOR_SKY;
                  end
                  fplb_pkg::PH_NEAR_BREAKOFF: begin
                     shown_count_in = prod_neg ? 6'd0 : lit_fill;
                     shown_color_in = fplb_pkg::COLOR_GREEN;
                  end
                  fplb_pkg::PH_BREAKOFF: begin
                     shown_count_in = step_ff[0] ? 6'd0 : n_ff;
                     shown_color_in = fplb_pkg::COLOR_GREEN;
                  end
                  fplb_pkg::PH_TRACK: begin
                     shown_count_in = prod_neg ? 6'd0 : lit_fill;
                     shown_color_in = fplb_pkg::COLOR_RED;
                  end
                  fplb_pkg::PH_DEPLOY: begin
                     shown_count_in = step_ff[0] ? 6'd0 : n_ff;
                     shown_color_in = fplb_pkg::COLOR_RED;
                  end
                  fplb_pkg::PH_CANOPY: begin
                     shown_count_in = quot[0] ? 6'd0 : n_ff;
                     shown_color_in = fplb_pkg::COLOR_PURPLE;
                  end
                  default: begin
                     shown_count_in = shown_count_ff;
                  end
               endcase
               out_count_in = shown_count_in;
               out_color_in = shown_color_in;
               out_level_in = shown_level_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      phase_in_reg: begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         alt_ff       <= alt_in;
         now_ff       <= now_in;
         n_ff         <= n_in;
         len_ff       <= len_in;
         diff_ff      <= diff_in;
         factor_ff    <= factor_in;
         span_pos_ff  <= span_pos_in;
         den_ff       <= den_in;
         prod_ff      <= prod_in;
         cyc_end_ff   <= cyc_end_in;
         off_end_ff   <= off_end_in;
         out_count_ff <= out_count_in;
         out_color_ff <= out_color_in;
         out_level_ff <= out_level_in;
      end
      if (reset) begin
         state_ff       <= S_IDLE;
         cs_ff          <= '0;
         shown_count_ff <= '0;
         shown_color_ff <= fplb_pkg::COLOR_PURPLE;
         shown_level_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cs_ff          <= cs_in;
         shown_count_ff <= shown_count_in;
         shown_color_ff <= shown_color_in;
         shown_level_ff <= shown_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

### rtl/fplb_checker.sv
// Port-level checks of the LED bar block, bound to its top level.
`include "assert_macros.svh"

module fplb_checker #(
   parameter int MAX_LEDS = 32
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [5:0]          rsp_lit_count,
   input fplb_pkg::color_type rsp_color
);

   `ASSERT_AFTER_RESET(a_reset_clears_result, clock, reset, !rsp_valid)
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_color_known, clock, reset, rsp_valid, rsp_color <= fplb_pkg::COLOR_RED)
   `ASSERT_IMPLIES(a_count_in_bar, clock, reset, rsp_valid, rsp_lit_count <= MAX_LEDS)

endmodule

bind flight_phase_led_bar_pattern fplb_checker #(.MAX_LEDS(MAX_LEDS)) u_fplb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_lit_count (rsp_bus.lit_count),
   .rsp_color     (rsp_bus.color)
);

### sim/flight_phase_led_bar_pattern_test.sv
// Self-checking testbench for the LED bar block: directed table, then random updates.
module flight_phase_led_bar_pattern_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fplb_pkg::*;

   localparam int HALF_PERIOD_NS = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int BAR_MAX_LEDS   = 32;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ROUNDS  = 8;
   localparam int ROUND_UPDATES  = 250;

   localparam phase_type     PH_UNDEFINED_FIRST = 4'd10;
   localparam phase_type     PH_UNDEFINED_LAST  = 4'd15;
   localparam csr_index_type CSR_SPARE          = 4'd15;

   typedef struct packed {
      logic [5:0] lit_count;
      color_type  color;
      logic [7:0] level;
   } bar_type;

   typedef enum {ROW_UPDATE, ROW_WRITE} row_kind_e;
   typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_e;

   typedef struct {
      row_kind_e     kind;
      phase_type     ph;
      logic [15:0]   stp;
      logic [15:0]   alt;
      logic [31:0]   now_ms;
      csr_index_type idx;
      logic [15:0]   value;
      bit            known;
      bar_type       bar;
   } probe_row_type;

   localparam cfg_type CFG_AT_RESET = '{6'd10, 16'd4500, 16'd13500, 16'd3500,
                                        16'd100, 16'd2000, 8'd10, 8'd100};

   logic clock = 1'b0;
   logic reset;

   fplb_req_if req_chan ();
   fplb_rsp_if rsp_chan ();
   fplb_csr_if csr_chan ();

   flight_phase_led_bar_pattern #(.MAX_LEDS(BAR_MAX_LEDS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan),
      .csr_bus (csr_chan)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   cfg_type     cfg = CFG_AT_RESET;
   logic [31:0] cycle_origin = '0;
   logic [5:0]  disp_count = '0;
   color_type   disp_color = COLOR_PURPLE;
   logic [7:0]  disp_level = '0;

   bar_type     pending_bars [$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   sink_mode_e  sink_mode = SINK_OPEN;
   int          sink_left = 0;
   int          sink_tick = 0;

   probe_row_type probe_table [27] = '{
      '{ROW_UPDATE, PH_UNDEFINED_LAST, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd0, COLOR_PURPLE, 8'd0}},
      '{ROW_UPDATE, PH_AWAIT_JUMP, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd10, COLOR_SKY, 8'd100}},
      '{ROW_UPDATE, PH_STANDBY, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd10, COLOR_PURPLE, 8'd10}},
      '{ROW_UPDATE, PH_STANDBY, 16'hFFFF, 16'd0, 32'd2999, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd0, COLOR_PURPLE, 8'd10}},
      '{ROW_UPDATE, PH_STANDBY, 16'd0, 16'd0, 32'd3000, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd0, COLOR_PURPLE, 8'd10}},
      '{ROW_UPDATE, PH_STANDBY, 16'd0, 16'd0, 32'd3500, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd0, COLOR_GREEN, 8'd10}},
      '{ROW_UPDATE, PH_ASCENT, 16'd0, 16'd0, 32'd5001, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd10, COLOR_YELLOW, 8'd100}},
      '{ROW_UPDATE, PH_ASCENT, 16'd0, 16'd0, 32'd5101, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_GEAR_CHECK, 16'd6, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_GEAR_CHECK, 16'd7, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_FREEFALL, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd10, COLOR_SKY, 8'd100}},
      '{ROW_UPDATE, PH_FREEFALL, 16'd0, 16'hFFFF, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd0, COLOR_SKY, 8'd100}},
      '{ROW_UPDATE, PH_FREEFALL, 16'd0, 16'd13500, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_NEAR_BREAKOFF, 16'd0, 16'd6000, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_NEAR_BREAKOFF, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_BREAKOFF, 16'd1, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_TRACK, 16'd0, 16'd3999, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_DEPLOY, 16'hFFFE, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_CANOPY, 16'd10, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_STANDBY, 16'd0, 16'd0, 32'hFFFF_FFFF, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_ASCENT, 16'd0, 16'd0, 32'd100, CSR_NUM_LEDS, 16'd0, 1'b0, '0},
      '{ROW_UPDATE, PH_UNDEFINED_FIRST, 16'hFFFF, 16'hFFFF, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b0,
        '0},
      '{ROW_WRITE, PH_STANDBY, 16'd0, 16'd0, 32'd0, CSR_SPARE, 16'hFFFF, 1'b0, '0},
      '{ROW_WRITE, PH_STANDBY, 16'd0, 16'd0, 32'd0, CSR_EXIT_ALT, 16'd5999, 1'b0, '0},
      '{ROW_UPDATE, PH_FREEFALL, 16'd0, 16'hFFFF, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd10, COLOR_SKY, 8'd100}},
      '{ROW_WRITE, PH_STANDBY, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'hFFFF, 1'b0, '0},
      '{ROW_UPDATE, PH_AWAIT_JUMP, 16'd0, 16'd0, 32'd0, CSR_NUM_LEDS, 16'd0, 1'b1,
        '{6'd32, COLOR_SKY, 8'd100}}
   };

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q -= 1;
      return q;
   endfunction

   function automatic logic [5:0] clamp_lit(longint v, logic [5:0] n);
      longint lim;
      lim = n;
      if (v < 0) return '0;
      if (v > lim) return n;
      return v[5:0];
   endfunction

   function automatic void run_timed_cycle(logic [31:0] now_ms, logic [5:0] n, color_type col);
      logic [31:0] cycle_len;
      logic [31:0] cycle_end;
      logic [31:0] off_end;
      cycle_len = cfg.flash_on_ms;
      cycle_len = cycle_len + cfg.flash_off_ms;
      cycle_end = cycle_origin + cycle_len;
      off_end   = cfg.flash_off_ms;
      off_end   = cycle_origin + off_end;
      if (now_ms > cycle_end) begin
         cycle_origin = now_ms;
      end else begin
         disp_count = (off_end < now_ms) ? n : 6'd0;
         disp_color = col;
      end
   endfunction

   function automatic bar_type compute_bar(phase_type ph, logic [15:0] stp, logic [15:0] alt,
                                           logic [31:0] now_ms);
      logic [5:0]  n;
      logic [15:0] stp_group;
      longint      nn, alt_ft, exit_ft, brk_ft, dep_ft, brk_margin, dep_margin, span;
      n          = (cfg.num_leds > BAR_MAX_LEDS) ? 6'(BAR_MAX_LEDS) : cfg.num_leds;
      nn         = n;
      alt_ft     = alt;
      exit_ft    = cfg.exit_altitude;
      brk_margin = BREAKOFF_MARGIN_FT;
      dep_margin = DEPLOY_MARGIN_FT;
      brk_ft     = cfg.breakoff_altitude;
      brk_ft     = brk_ft + brk_margin;
      dep_ft     = cfg.deploy_altitude;
      dep_ft     = dep_ft + dep_margin;
      if (ph <= PH_CANOPY) disp_level = (ph == PH_STANDBY) ? cfg.standby_level : cfg.flight_level;
      case (ph)
         PH_STANDBY: begin
            if (cycle_origin == 0 && now_ms < BLINK_WINDOW_MS) begin
               disp_count = stp[0] ? 6'd0 : n;
               disp_color = COLOR_PURPLE;
            end else begin
               run_timed_cycle(now_ms, n, COLOR_GREEN);
            end
         end
         PH_ASCENT: run_timed_cycle(now_ms, n, COLOR_YELLOW);
         PH_GEAR_CHECK: begin
            stp_group  = stp / GEAR_STEP_DIV;
            disp_count = stp_group[0] ? 6'd0 : n;
            disp_color = COLOR_GREEN;
         end
         PH_AWAIT_JUMP: begin
            disp_count = n;
            disp_color = COLOR_SKY;
         end
         PH_FREEFALL: begin
            span = exit_ft - brk_ft;
            if (span <= 0) disp_count = n;
            else disp_count = clamp_lit(floor_quot(nn * (exit_ft - alt_ft), span) + 1, n);
            disp_color = COLOR_SKY;
         end
         PH_NEAR_BREAKOFF: begin
            disp_count = clamp_lit(floor_quot((nn + 1) * (brk_ft - alt_ft), brk_margin), n);
            disp_color = COLOR_GREEN;
         end
         PH_BREAKOFF: begin
            disp_count = stp[0] ? 6'd0 : n;
            disp_color = COLOR_GREEN;
         end
         PH_TRACK: begin
            disp_count = clamp_lit(floor_quot((nn + 1) * (dep_ft - alt_ft), dep_margin), n);
            disp_color = COLOR_RED;
         end
         PH_DEPLOY: begin
            disp_count = stp[0] ? 6'd0 : n;
            disp_color = COLOR_RED;
         end
         PH_CANOPY: begin
            stp_group  = stp / CANOPY_STEP_DIV;
            disp_count = stp_group[0] ? 6'd0 : n;
            disp_color = COLOR_PURPLE;
         end
         default: ;
      endcase
      return '{disp_count, disp_color, disp_level};
   endfunction

   task automatic drain_bars();
      req_chan.valid <= 1'b0;
      while (pending_bars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic send_update(phase_type ph, logic [15:0] stp, logic [15:0] alt,
                              logic [31:0] now_ms, bit known, bar_type known_bar);
      bar_type bar;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.phase    <= ph;
      req_chan.step     <= stp;
      req_chan.altitude <= alt;
      req_chan.now_ms   <= now_ms;
      do @(posedge clock); while (!req_chan.ready);
      bar = compute_bar(ph, stp, alt, now_ms);
      pending_bars.push_back(known ? known_bar : bar);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_NUM_LEDS:      cfg.num_leds          = value[5:0];
         CSR_BREAKOFF_ALT:  cfg.breakoff_altitude = value;
         CSR_EXIT_ALT:      cfg.exit_altitude     = value;
         CSR_DEPLOY_ALT:    cfg.deploy_altitude   = value;
         CSR_FLASH_ON:      cfg.flash_on_ms       = value;
         CSR_FLASH_OFF:     cfg.flash_off_ms      = value;
         CSR_STANDBY_LEVEL: cfg.standby_level     = value[7:0];
         CSR_FLIGHT_LEVEL:  cfg.flight_level      = value[7:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      bar_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bars.size() == 0) begin
            $error("result transfer with no update outstanding");
            mismatches++;
         end else begin
            want = pending_bars.pop_front();
            if (rsp_chan.lit_count !== want.lit_count) begin
               $error("lit_count: expected %0d, got %0d", want.lit_count, rsp_chan.lit_count);
               mismatches++;
            end
            if (rsp_chan.color !== want.color) begin
               $error("color: expected %0d, got %0d", want.color, rsp_chan.color);
               mismatches++;
            end
            if (rsp_chan.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_chan.level);
               mismatches++;
            end
         end
      end
      if (sink_left == 0) begin
         sink_mode = sink_mode_e'($urandom_range(0, 2));
         sink_left = $urandom_range(16, 160);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
         SINK_OPEN:     rsp_chan.ready <= 1'b1;
         SINK_RANDOM:   rsp_chan.ready <= $urandom_range(0, 1);
         SINK_PERIODIC: rsp_chan.ready <= (sink_tick % 5) < 2;
         default:       rsp_chan.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type     corner_settings [4];
      cfg_type     s;
      logic [15:0] junk;
      logic [31:0] ms_now;
      phase_type   ph;
      int          a;
      csr_index_type reg_order [8];

      corner_settings = '{
         '{6'd32, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255},
         '{6'd1, 16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd65535, 8'd0, 8'd0},
         '{6'd63, 16'd6000, 16'd7500, 16'd2000, 16'd300, 16'd700, 8'd128, 8'd200},
         '{6'd0, 16'd4500, 16'd13500, 16'd3500, 16'd100, 16'd2000, 8'd10, 8'd100}
      };
      reg_order = '{CSR_NUM_LEDS, CSR_BREAKOFF_ALT, CSR_EXIT_ALT, CSR_DEPLOY_ALT,
                    CSR_FLASH_ON, CSR_FLASH_OFF, CSR_STANDBY_LEVEL, CSR_FLIGHT_LEVEL};

      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.phase    = PH_STANDBY;
      req_chan.step     = '0;
      req_chan.altitude = '0;
      req_chan.now_ms   = '0;
      rsp_chan.ready    = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = CSR_NUM_LEDS;
      csr_chan.data     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         if (probe_table[i].kind == ROW_WRITE) begin
            drain_bars();
            write_register(probe_table[i].idx, probe_table[i].value);
            csr_chan.valid <= 1'b0;
         end else begin
            send_update(probe_table[i].ph, probe_table[i].stp, probe_table[i].alt,
                        probe_table[i].now_ms, probe_table[i].known, probe_table[i].bar);
         end
      end

      ms_now = $urandom_range(0, 5000);
      for (int r = 0; r < RANDOM_ROUNDS; r++) begin
         if (r < 4) begin
            s = corner_settings[r];
         end else begin
            s.num_leds          = $urandom_range(1, BAR_MAX_LEDS);
            s.breakoff_altitude = $urandom_range(1000, 8000);
            s.exit_altitude     = s.breakoff_altitude + 1500 + $urandom_range(1, 20000);
            s.deploy_altitude   = $urandom_range(0, s.breakoff_altitude);
            s.flash_on_ms       = $urandom_range(0, 1000);
            s.flash_off_ms      = $urandom_range(0, 3000);
            s.standby_level     = $urandom;
            s.flight_level      = $urandom;
         end
         drain_bars();
         foreach (reg_order[k]) begin
            junk = $urandom;
            case (reg_order[k])
               CSR_NUM_LEDS:      write_register(reg_order[k], {junk[15:6], s.num_leds});
               CSR_BREAKOFF_ALT:  write_register(reg_order[k], s.breakoff_altitude);
               CSR_EXIT_ALT:      write_register(reg_order[k], s.exit_altitude);
               CSR_DEPLOY_ALT:    write_register(reg_order[k], s.deploy_altitude);
               CSR_FLASH_ON:      write_register(reg_order[k], s.flash_on_ms);
               CSR_FLASH_OFF:     write_register(reg_order[k], s.flash_off_ms);
               CSR_STANDBY_LEVEL: write_register(reg_order[k], {junk[15:8], s.standby_level});
               default:           write_register(reg_order[k], {junk[15:8], s.flight_level});
            endcase
         end
         csr_chan.valid <= 1'b0;

         repeat (ROUND_UPDATES) begin
            a = $urandom_range(0, 99);
            if (a < 5) ms_now = $urandom;
            else if (a >= 15)
               ms_now = ms_now + $urandom_range(0, (cfg.flash_on_ms + cfg.flash_off_ms) / 2 + 400);
            ph = ($urandom_range(0, 99) < 6) ? phase_type'($urandom_range(10, 15))
                                             : phase_type'($urandom_range(0, 9));
            if ($urandom_range(0, 4) == 0) begin
               a = $urandom_range(0, 65535);
            end else begin
               case ($urandom_range(0, 3))
                  0:       a = cfg.exit_altitude;
                  1:       a = cfg.breakoff_altitude + 1500;
                  2:       a = cfg.deploy_altitude + 500;
                  default: a = cfg.breakoff_altitude;
               endcase
               a = a + int'($urandom_range(0, 4000)) - 2000;
               if (a < 0) a = 0;
               if (a > 65535) a = 65535;
            end
            send_update(ph, 16'($urandom), 16'(a), ms_now, 1'b0, '0);
            if ($urandom_range(0, 149) == 0) drain_bars();
         end
      end

      drain_bars();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_bars.size() != 0) begin
         $error("%0d results never arrived", pending_bars.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
